// File: rtl/alip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alip_pkg: shared types and constants for the ADC-to-lux interpolator
// Fixed field widths, register map codes, table reset values and the
// control bundle handed along the divider cell chains.
// ----------------------------------------------------------------------------
package alip_pkg;

  localparam int SAMPLE_W    = 12;  // converter sample
  localparam int R_W         = 16;  // divider resistance, Q4.12
  localparam int R_FRAC_BITS = 12;
  localparam int DIV_GAIN    = 10;  // resistance gain of the divider formula
  localparam int GAIN_W      = 4;   // bits to hold DIV_GAIN
  localparam int PT_W        = 16;  // one table point register
  localparam int LUX_W       = 20;  // result lux, Q16.4
  localparam int LUX_FRAC_W  = 4;
  localparam int TABLE_SLOTS = 4;   // register slots per table column
  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 32;

  typedef logic [PT_W-1:0] pt_t;

  typedef enum logic [2:0] {
    REG_LUX0,
    REG_LUX1,
    REG_LUX2,
    REG_LUX3,
    REG_OHMS0,
    REG_OHMS1,
    REG_OHMS2,
    REG_OHMS3
  } reg_idx_t;

  localparam pt_t LUX_RST [TABLE_SLOTS] = '{16'd10, 16'd100, 16'd999, 16'd1000};
  localparam pt_t OHMS_RST [TABLE_SLOTS] = '{16'd32768, 16'd4096, 16'd410, 16'd0};

  typedef struct packed {
    logic en;     // whole pipeline advances
    logic valid;  // item present in the feeding stage
  } cell_ctl_t;

endpackage

// File: rtl/alip_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alip_div_cell: one restoring-division cell
// Takes one dividend bit, produces one quotient bit and hands the partial
// remainder, divisor and side data to the next cell.
// ----------------------------------------------------------------------------
module alip_div_cell #(
  parameter int DW = 16,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  alip_pkg::cell_ctl_t ctl_in,
  input  logic [DW-1:0]       rem_in,
  input  logic [DW-1:0]       dsr_in,
  input  logic [QW-1:0]       dvd_in,
  input  logic [QW-1:0]       quo_in,
  input  logic [SW-1:0]       side_in,
  output logic                v_out,
  output logic [DW-1:0]       rem_out,
  output logic [DW-1:0]       dsr_out,
  output logic [QW-1:0]       dvd_out,
  output logic [QW-1:0]       quo_out,
  output logic [SW-1:0]       side_out
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;
  logic          v_r;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dsr_r;
  logic [QW-1:0] dvd_r, dvd_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [SW-1:0] side_r;

  // shift in the next dividend bit and try the subtract
  assign trial   = {rem_in, dvd_in[QW-1]};
  assign diff    = trial - {1'b0, dsr_in};
  assign fits    = (trial >= {1'b0, dsr_in});
  assign rem_nxt = fits ? diff[DW-1:0] : trial[DW-1:0];
  assign dvd_nxt = {dvd_in[QW-2:0], 1'b0};
  assign quo_nxt = {quo_in[QW-2:0], fits};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ctl_in.en) begin
      v_r <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      rem_r  <= rem_nxt;
      dsr_r  <= dsr_in;
      dvd_r  <= dvd_nxt;
      quo_r  <= quo_nxt;
      side_r <= side_in;
    end
  end

  assign v_out    = v_r;
  assign rem_out  = rem_r;
  assign dsr_out  = dsr_r;
  assign dvd_out  = dvd_r;
  assign quo_out  = quo_r;
  assign side_out = side_r;

endmodule

// File: rtl/alip_div_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alip_div_chain: pipelined unsigned divider built from a row of cells
// One quotient bit per cell; one item may enter every cycle while en is high. The upper
// dividend part must be below the divisor for the quotient to fit QW bits.
// ----------------------------------------------------------------------------
module alip_div_chain #(
  parameter int DW = 16,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_in,
  input  logic [DW-1:0] rem_in,
  input  logic [QW-1:0] dvd_in,
  input  logic [DW-1:0] dsr_in,
  input  logic [SW-1:0] side_in,
  output logic          v_out,
  output logic [QW-1:0] quo_out,
  output logic [SW-1:0] side_out
);
  import alip_pkg::*;

  logic          v_s    [0:QW];
  logic [DW-1:0] rem_s  [0:QW];
  logic [DW-1:0] dsr_s  [0:QW];
  logic [QW-1:0] dvd_s  [0:QW];
  logic [QW-1:0] quo_s  [0:QW];
  logic [SW-1:0] side_s [0:QW];
  cell_ctl_t     ctl_s  [0:QW-1];

  assign v_s[0]    = v_in;
  assign rem_s[0]  = rem_in;
  assign dsr_s[0]  = dsr_in;
  assign dvd_s[0]  = dvd_in;
  assign quo_s[0]  = '0;
  assign side_s[0] = side_in;

  for (genvar k = 0; k < QW; k++) begin : g_cell
    assign ctl_s[k].en    = en;
    assign ctl_s[k].valid = v_s[k];

    alip_div_cell #(
      .DW(DW),
      .QW(QW),
      .SW(SW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_in  (ctl_s[k]),
      .rem_in  (rem_s[k]),
      .dsr_in  (dsr_s[k]),
      .dvd_in  (dvd_s[k]),
      .quo_in  (quo_s[k]),
      .side_in (side_s[k]),
      .v_out   (v_s[k+1]),
      .rem_out (rem_s[k+1]),
      .dsr_out (dsr_s[k+1]),
      .dvd_out (dvd_s[k+1]),
      .quo_out (quo_s[k+1]),
      .side_out(side_s[k+1])
    );
  end

  assign v_out    = v_s[QW];
  assign quo_out  = quo_s[QW];
  assign side_out = side_s[QW];

endmodule

// File: rtl/adc_to_lux_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_to_lux_interpolator: light sensor linearizer
// Converts a divider ADC sample to resistance, then to lux by piecewise
// linear interpolation over a programmable four-point table.
// ----------------------------------------------------------------------------
// A new item can enter every clock cycle while in_stall is low. Each item
// passes in order through three front stages, a pipelined restoring divider
// of 16 cells for the resistance sample*10*4096/(full_scale-sample), three
// middle stages, a second such divider of 20 cells for the interpolation
// step and the output register; each divider cell yields one quotient bit.
// The resistance saturates at 0xFFFF. A sample at or above full scale, or a
// resistance above the first table point or at or below the last, gives lux
// 0 with in_range low. The table lives in eight 16-bit APB registers at byte
// addresses 0x00..0x1C: lux points 0..3, then resistance points 0..3 in
// Q4.12, meant to descend. Write the table only while no item is in flight.
// in_stall comes straight from a register (the output skid entry), so the
// two sides never form a combinational path.
// ----------------------------------------------------------------------------
module adc_to_lux_interpolator #(
  parameter int NUM_POINTS     = 4,
  parameter int ADC_FULL_SCALE = 4095
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input items
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [alip_pkg::SAMPLE_W-1:0]  in_adc_sample,
  // result items
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [alip_pkg::LUX_W-1:0]     out_lux_value,
  output logic                           out_in_range,
  // configuration
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [alip_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [alip_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [alip_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                           cfg_pready
);
  import alip_pkg::*;

  localparam int DW1   = $clog2(ADC_FULL_SCALE + 1);
  localparam int NUM_W = SAMPLE_W + GAIN_W + R_FRAC_BITS;
  localparam int SCW   = (SAMPLE_W > DW1) ? SAMPLE_W : DW1;
  localparam int SATW  = (NUM_W > DW1 + R_W) ? NUM_W : DW1 + R_W;
  localparam int NSEG  = NUM_POINTS - 1;
  localparam int SW2   = 2 + PT_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  pt_t      lux_pt_r [TABLE_SLOTS];
  pt_t      ohm_pt_r [TABLE_SLOTS];
  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lux_pt_r <= LUX_RST;
      ohm_pt_r <= OHMS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LUX0:  lux_pt_r[0] <= cfg_pwdata[PT_W-1:0];
        REG_LUX1:  lux_pt_r[1] <= cfg_pwdata[PT_W-1:0];
        REG_LUX2:  lux_pt_r[2] <= cfg_pwdata[PT_W-1:0];
        REG_LUX3:  lux_pt_r[3] <= cfg_pwdata[PT_W-1:0];
        REG_OHMS0: ohm_pt_r[0] <= cfg_pwdata[PT_W-1:0];
        REG_OHMS1: ohm_pt_r[1] <= cfg_pwdata[PT_W-1:0];
        REG_OHMS2: ohm_pt_r[2] <= cfg_pwdata[PT_W-1:0];
        REG_OHMS3: ohm_pt_r[3] <= cfg_pwdata[PT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LUX0:  cfg_prdata = CFG_DW'(lux_pt_r[0]);
      REG_LUX1:  cfg_prdata = CFG_DW'(lux_pt_r[1]);
      REG_LUX2:  cfg_prdata = CFG_DW'(lux_pt_r[2]);
      REG_LUX3:  cfg_prdata = CFG_DW'(lux_pt_r[3]);
      REG_OHMS0: cfg_prdata = CFG_DW'(ohm_pt_r[0]);
      REG_OHMS1: cfg_prdata = CFG_DW'(ohm_pt_r[1]);
      REG_OHMS2: cfg_prdata = CFG_DW'(ohm_pt_r[2]);
      REG_OHMS3: cfg_prdata = CFG_DW'(ohm_pt_r[3]);
      default:   cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: every stage moves together unless the skid entry is
  // occupied. Since the skid flag is registered, at most one extra item
  // drops out of the pipeline after the output stalls, and it lands there.
  // --------------------------------------------------------------------------
  logic en;
  logic skid_v_r;

  assign en       = ~skid_v_r;
  assign in_stall = skid_v_r;

  // --------------------------------------------------------------------------
  // Stage 0: capture the sample
  // --------------------------------------------------------------------------
  logic                s0_v_r;
  logic [SAMPLE_W-1:0] s0_sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_sample_r <= in_adc_sample;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: numerator sample*10 in Q.12, denominator full_scale - sample,
  // and flag samples at or above full scale (no valid divide)
  // --------------------------------------------------------------------------
  logic             s1_v_r;
  logic [NUM_W-1:0] s1_num_r, s1_num_nxt;
  logic [DW1-1:0]   s1_den_r, s1_den_nxt;
  logic             s1_bad_r, s1_bad_nxt;

  assign s1_num_nxt = (NUM_W'(s0_sample_r) * NUM_W'(DIV_GAIN)) << R_FRAC_BITS;
  assign s1_den_nxt = DW1'(ADC_FULL_SCALE) - DW1'(s0_sample_r);
  assign s1_bad_nxt = (SCW'(s0_sample_r) >= SCW'(ADC_FULL_SCALE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_num_r <= s1_num_nxt;
      s1_den_r <= s1_den_nxt;
      s1_bad_r <= s1_bad_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: saturation check. A quotient of 2^16 or more clamps to 0xFFFF;
  // otherwise the upper numerator bits sit below the divisor and seed the
  // first cell's partial remainder.
  // --------------------------------------------------------------------------
  logic           s2_v_r;
  logic [DW1-1:0] s2_rem_r;
  logic [R_W-1:0] s2_dvd_r;
  logic [DW1-1:0] s2_den_r;
  logic [1:0]     s2_side_r, s2_side_nxt;  // {bad, sat}
  logic           s2_sat;

  assign s2_sat      = (SATW'(s1_num_r) >= (SATW'(s1_den_r) << R_W));
  assign s2_side_nxt = {s1_bad_r, s2_sat};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_rem_r  <= DW1'(s1_num_r >> R_W);
      s2_dvd_r  <= s1_num_r[R_W-1:0];
      s2_den_r  <= s1_den_r;
      s2_side_r <= s2_side_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Resistance divider: 16 cells
  // --------------------------------------------------------------------------
  logic           c1_v;
  logic [R_W-1:0] c1_quo;
  logic [1:0]     c1_side;

  alip_div_chain #(
    .DW(DW1),
    .QW(R_W),
    .SW(2)
  ) u_res_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_in    (s2_v_r),
    .rem_in  (s2_rem_r),
    .dvd_in  (s2_dvd_r),
    .dsr_in  (s2_den_r),
    .side_in (s2_side_r),
    .v_out   (c1_v),
    .quo_out (c1_quo),
    .side_out(c1_side)
  );

  // --------------------------------------------------------------------------
  // Stage 3: clamp resistance and test each segment hi >= R > lo
  // --------------------------------------------------------------------------
  logic            s3_v_r;
  logic [R_W-1:0]  s3_res_r, s3_res_nxt;
  logic [NSEG-1:0] s3_hit_r, s3_hit_nxt;

  assign s3_res_nxt = c1_side[0] ? '1 : c1_quo;

  always_comb begin
    for (int k = 0; k < NSEG; k++) begin
      s3_hit_nxt[k] = ~c1_side[1] && (s3_res_nxt > ohm_pt_r[k+1]) &&
                      (s3_res_nxt <= ohm_pt_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= c1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_res_r <= s3_res_nxt;
      s3_hit_r <= s3_hit_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: pick the first matching segment, form offset, span and the
  // lux step as magnitude plus sign
  // --------------------------------------------------------------------------
  logic            s4_v_r;
  logic [NSEG-1:0] s4_first;
  logic            s4_any;
  pt_t             s4_hi, s4_lo, s4_l0, s4_l1;
  logic            s4_neg_nxt;
  pt_t             s4_off_r, s4_span_r, s4_mag_r, s4_base_r, s4_mag_nxt;
  logic            s4_neg_r, s4_hit_r;

  always_comb begin
    s4_any = 1'b0;
    s4_hi  = '0;
    s4_lo  = '0;
    s4_l0  = '0;
    s4_l1  = '0;
    for (int k = 0; k < NSEG; k++) begin
      s4_first[k] = s3_hit_r[k] & ~s4_any;
      s4_any      = s4_any | s3_hit_r[k];
      s4_hi       = s4_hi | ({PT_W{s4_first[k]}} & ohm_pt_r[k]);
      s4_lo       = s4_lo | ({PT_W{s4_first[k]}} & ohm_pt_r[k+1]);
      s4_l0       = s4_l0 | ({PT_W{s4_first[k]}} & lux_pt_r[k]);
      s4_l1       = s4_l1 | ({PT_W{s4_first[k]}} & lux_pt_r[k+1]);
    end
  end

  assign s4_neg_nxt = (s4_l1 < s4_l0);
  assign s4_mag_nxt = s4_neg_nxt ? (s4_l0 - s4_l1) : (s4_l1 - s4_l0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_off_r  <= s4_hi - s3_res_r;
      s4_span_r <= s4_hi - s4_lo;
      s4_mag_r  <= s4_mag_nxt;
      s4_neg_r  <= s4_neg_nxt;
      s4_base_r <= s4_l0;
      s4_hit_r  <= s4_any;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: |lux step| * offset. Scaled by 16 this stays below span << 20,
  // so the quotient fits the 20 cells that follow.
  // --------------------------------------------------------------------------
  logic              s5_v_r;
  logic [2*PT_W-1:0] s5_prod_r;
  pt_t               s5_span_r;
  logic [SW2-1:0]    s5_side_r;  // {hit, neg, base}

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_prod_r <= (2*PT_W)'(s4_mag_r) * (2*PT_W)'(s4_off_r);
      s5_span_r <= s4_span_r;
      s5_side_r <= {s4_hit_r, s4_neg_r, s4_base_r};
    end
  end

  // --------------------------------------------------------------------------
  // Interpolation divider: 20 cells, quotient is the lux offset in Q.4
  // --------------------------------------------------------------------------
  logic             c2_v;
  logic [LUX_W-1:0] c2_quo;
  logic [SW2-1:0]   c2_side;
  logic [LUX_W-1:0] c2_dvd;

  assign c2_dvd = {s5_prod_r[PT_W-1:0], LUX_FRAC_W'(0)};

  alip_div_chain #(
    .DW(PT_W),
    .QW(LUX_W),
    .SW(SW2)
  ) u_lux_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_in    (s5_v_r),
    .rem_in  (s5_prod_r[2*PT_W-1:PT_W]),
    .dvd_in  (c2_dvd),
    .dsr_in  (s5_span_r),
    .side_in (s5_side_r),
    .v_out   (c2_v),
    .quo_out (c2_quo),
    .side_out(c2_side)
  );

  // --------------------------------------------------------------------------
  // Result: base*16 plus or minus the truncated offset, zero when no segment
  // matched. The value always lies between the two endpoints.
  // --------------------------------------------------------------------------
  logic [LUX_W:0]   res_base;
  logic [LUX_W:0]   res_sum;
  logic [LUX_W-1:0] res_lux;
  logic             res_hit;
  logic             res_fire;

  assign res_hit  = c2_side[SW2-1];
  assign res_base = (LUX_W+1)'(c2_side[PT_W-1:0]) << LUX_FRAC_W;
  assign res_sum  = c2_side[PT_W] ? (res_base - (LUX_W+1)'(c2_quo))
                                  : (res_base + (LUX_W+1)'(c2_quo));
  assign res_lux  = res_hit ? res_sum[LUX_W-1:0] : '0;
  assign res_fire = c2_v & en;

  // --------------------------------------------------------------------------
  // Output register with one skid entry. Load the output when it is empty or
  // being taken; park a result in the skid entry when the output is stalled.
  // --------------------------------------------------------------------------
  logic             out_valid_r, out_valid_nxt;
  logic [LUX_W-1:0] out_lux_r, out_lux_nxt;
  logic             out_rng_r, out_rng_nxt;
  logic             skid_v_nxt;
  logic [LUX_W-1:0] skid_lux_r, skid_lux_nxt;
  logic             skid_rng_r, skid_rng_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_lux_nxt   = out_lux_r;
    out_rng_nxt   = out_rng_r;
    skid_v_nxt    = skid_v_r;
    skid_lux_nxt  = skid_lux_r;
    skid_rng_nxt  = skid_rng_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_v_r) begin
        out_valid_nxt = 1'b1;
        out_lux_nxt   = skid_lux_r;
        out_rng_nxt   = skid_rng_r;
        skid_v_nxt    = 1'b0;
      end else begin
        out_valid_nxt = res_fire;
        out_lux_nxt   = res_lux;
        out_rng_nxt   = res_hit;
      end
    end else if (res_fire) begin
      skid_v_nxt   = 1'b1;
      skid_lux_nxt = res_lux;
      skid_rng_nxt = res_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_v_r    <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_lux_r  <= out_lux_nxt;
    out_rng_r  <= out_rng_nxt;
    skid_lux_r <= skid_lux_nxt;
    skid_rng_r <= skid_rng_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_lux_value = out_lux_r;
  assign out_in_range  = out_rng_r;

endmodule
